// ===== sv/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared constants and types of the controller frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

   localparam int FRAME_BYTES = 10;
   localparam int IDX_W       = $clog2(FRAME_BYTES + 1);

   localparam int BYTE_W      = 8;
   localparam int RAW_W       = 16;
   localparam int GAIN_W      = 28;
   localparam int GAIN_FRAC   = 24;
   localparam int PROD_W      = RAW_W + GAIN_W;
   localparam int SPEED_W     = 19;
   localparam int DIST_W      = 32;

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(134075981);

   // speed * 5 / 36 is done as ((speed * 5) >> 2) / 9
   localparam int TIMES5_W    = SPEED_W + 3;
   localparam int DIV_IN_W    = TIMES5_W - 2;
   localparam int DIV9_SHIFT  = 24;
   localparam int RECIP_W     = 21;
   localparam logic [RECIP_W-1:0] DIV9_RECIP = RECIP_W'((2 ** DIV9_SHIFT) / 9);
   localparam int QUOT_W      = 17;
   localparam int REM_W       = 5;
   localparam logic [REM_W-1:0] DIVISOR_9 = REM_W'(9);

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [SPEED_W-1:0] speed_type;
   typedef logic [DIST_W-1:0]  dist_type;
   typedef logic [QUOT_W-1:0]  quot_type;

   typedef struct packed {
      logic             chk_ok;
      logic [RAW_W-1:0] raw;
      byte_type         current;
      byte_type         voltage;
      byte_type         status1;
      byte_type         status2;
   } frame_type;

   typedef struct packed {
      logic     chk_ok;
      byte_type current;
      byte_type voltage;
      byte_type status1;
      byte_type status2;
   } info_type;

endpackage

// ===== sv/cfr_if.sv =====
// ----------------------------------------------------------------------------
// cfr_if
// Valid/ready channels of the controller frame receiver.
// ----------------------------------------------------------------------------
interface cfr_req_if import cfr_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type rx_byte;
   logic     last_byte;

   modport source (output valid, rx_byte, last_byte, input ready);
   modport sink   (input valid, rx_byte, last_byte, output ready);
endinterface

interface cfr_rsp_if import cfr_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      frame_ok;
   speed_type speed_centi_kmh;
   byte_type  charge_current;
   byte_type  charge_voltage;
   byte_type  fault_status1;
   byte_type  fault_status2;
   dist_type  distance_cm;

   modport source (output valid, frame_ok, speed_centi_kmh, charge_current, charge_voltage,
                   fault_status1, fault_status2, distance_cm, input ready);
   modport sink   (input valid, frame_ok, speed_centi_kmh, charge_current, charge_voltage,
                   fault_status1, fault_status2, distance_cm, output ready);
endinterface

interface cfr_csr_if import cfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [GAIN_W-1:0] speed_gain;

   modport source (output valid, speed_gain, input ready);
   modport sink   (input valid, speed_gain, output ready);
endinterface

// ===== sv/cfr_frame_buf.sv =====
// ----------------------------------------------------------------------------
// cfr_frame_buf
// Frame byte store, checksum and field extraction at the buffer end.
// ----------------------------------------------------------------------------
module cfr_frame_buf import cfr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  byte_type  rx_byte,
   input  logic      last_byte,
   output frame_type frame
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   byte_type         bytes_ff [FRAME_BYTES];
   byte_type         bytes_in [FRAME_BYTES];
   byte_type         view     [FRAME_BYTES];
   byte_type         sum;

   always_comb begin
      for (int k = 0; k < FRAME_BYTES; k++) begin
         view[k] = (idx_ff == IDX_W'(k)) ? rx_byte : bytes_ff[k];
      end
      sum = '0;
      for (int k = 1; k <= 8; k++) begin
         sum = sum + view[k];
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      bytes_in = bytes_ff;
      if (accept) begin
         if (last_byte) begin
            idx_in = '0;
            for (int k = 0; k < FRAME_BYTES; k++) begin
               bytes_in[k] = '0;
            end
         end else if (idx_ff < IDX_W'(FRAME_BYTES)) begin
            idx_in   = idx_ff + IDX_W'(1);
            bytes_in = view;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         for (int k = 0; k < FRAME_BYTES; k++) begin
            bytes_ff[k] <= '0;
         end
      end else begin
         idx_ff   <= idx_in;
         bytes_ff <= bytes_in;
      end
   end

   assign frame.chk_ok  = (sum == view[9]);
   assign frame.raw     = {view[3], view[2]};
   assign frame.current = view[4];
   assign frame.voltage = view[5];
   assign frame.status1 = view[6];
   assign frame.status2 = view[7];

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_W'(FRAME_BYTES))
      else $error("byte index past frame length");

   a_idx_clear: assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> idx_ff == '0 && bytes_ff[9] == '0)
      else $error("frame store not cleared at buffer end");

endmodule

// ===== sv/controller_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// controller_frame_receiver
// Motor controller frame decoder: checksum, speed, distance, status bytes.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle with no gaps required unless rsp_ch.ready
// stalls fill the pipeline. A frame's result passes the input register, the
// speed-gain multiply, the reciprocal multiply for the divide by 9, its
// remainder fixup and the saturating distance add, each in its own pipeline
// register. The pipeline collapses bubbles, so bytes keep being taken while
// a result waits. The speed_gain register resets to 134075981 (Q24); the user
// writes it through the csr channel while no frame is in flight; not enforced.
module controller_frame_receiver import cfr_pkg::*; (
   input  logic clock,
   input  logic reset,
   cfr_req_if.sink   req_ch,
   cfr_rsp_if.source rsp_ch,
   cfr_csr_if.sink   csr_ch
);

   logic [GAIN_W-1:0]   gain_ff;
   frame_type           frame;
   logic                req_acc;

   logic                v1_ff, v2_ff, v3_ff, v4_ff, out_v_ff;
   logic                rdy1, rdy2, rdy3, rdy4, rdy_out;

   logic [RAW_W-1:0]    p1_raw_ff;
   info_type            p1_info_ff, p2_info_ff, p3_info_ff, p4_info_ff;
   speed_type           p2_speed_ff, p3_speed_ff, p4_speed_ff;
   logic [DIV_IN_W-1:0] p3_y_ff;
   quot_type            p3_q_ff, p4_inc_ff;

   logic [PROD_W-1:0]            prod;
   logic [PROD_W-GAIN_FRAC-1:0]  prod_int;
   speed_type                    speed_in;
   logic [TIMES5_W-1:0]          times5;
   logic [DIV_IN_W-1:0]          y_in;
   logic [DIV_IN_W+RECIP_W-1:0]  q_prod;
   logic [DIV_IN_W:0]            nine_q;
   logic [DIV_IN_W:0]            rem_full;
   quot_type                     inc_in;
   logic [DIST_W:0]              dist_sum;

   logic                frame_ok_ff;
   speed_type           speed_ff;
   byte_type            current_ff, voltage_ff, status1_ff, status2_ff;
   dist_type            dist_ff;

   // configuration
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_ch.valid) begin
         gain_ff <= csr_ch.speed_gain;
      end
   end

   // pipeline flow
   assign rdy_out = !out_v_ff || rsp_ch.ready;
   assign rdy4    = !v4_ff || rdy_out;
   assign rdy3    = !v3_ff || rdy4;
   assign rdy2    = !v2_ff || rdy3;
   assign rdy1    = !v1_ff || rdy2;

   assign req_ch.ready = rdy1;
   assign req_acc      = req_ch.valid && rdy1;

   cfr_frame_buf u_frame_buf (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_acc),
      .rx_byte   (req_ch.rx_byte),
      .last_byte (req_ch.last_byte),
      .frame     (frame)
   );

   // stage arithmetic
   assign prod     = PROD_W'(p1_raw_ff) * PROD_W'(gain_ff);
   assign prod_int = prod[PROD_W-1:GAIN_FRAC];
   assign speed_in = prod_int[SPEED_W] ? '1 : prod_int[SPEED_W-1:0];

   assign times5   = {p2_speed_ff, 2'b00} + TIMES5_W'(p2_speed_ff);
   assign y_in     = times5[TIMES5_W-1:2];
   assign q_prod   = (DIV_IN_W+RECIP_W)'(y_in) * (DIV_IN_W+RECIP_W)'(DIV9_RECIP);

   assign nine_q   = {1'b0, p3_q_ff, 3'b000} + (DIV_IN_W+1)'(p3_q_ff);
   assign rem_full = {1'b0, p3_y_ff} - nine_q;
   assign inc_in   = p3_q_ff + QUOT_W'(rem_full[REM_W-1:0] >= DIVISOR_9);

   assign dist_sum = {1'b0, dist_ff} + (DIST_W+1)'(p4_inc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         v4_ff       <= 1'b0;
         out_v_ff    <= 1'b0;
         frame_ok_ff <= 1'b0;
         speed_ff    <= '0;
         current_ff  <= '0;
         voltage_ff  <= '0;
         status1_ff  <= '0;
         status2_ff  <= '0;
         dist_ff     <= '0;
      end else begin
         if (rdy1) begin
            v1_ff <= req_acc && req_ch.last_byte;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
         if (rdy_out) begin
            out_v_ff <= v4_ff;
            if (v4_ff) begin
               frame_ok_ff <= p4_info_ff.chk_ok;
               if (p4_info_ff.chk_ok) begin
                  speed_ff   <= p4_speed_ff;
                  current_ff <= p4_info_ff.current;
                  voltage_ff <= p4_info_ff.voltage;
                  status1_ff <= p4_info_ff.status1;
                  status2_ff <= p4_info_ff.status2;
                  dist_ff    <= dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         p1_raw_ff          <= frame.raw;
         p1_info_ff.chk_ok  <= frame.chk_ok;
         p1_info_ff.current <= frame.current;
         p1_info_ff.voltage <= frame.voltage;
         p1_info_ff.status1 <= frame.status1;
         p1_info_ff.status2 <= frame.status2;
      end
      if (rdy2) begin
         p2_info_ff  <= p1_info_ff;
         p2_speed_ff <= speed_in;
      end
      if (rdy3) begin
         p3_info_ff  <= p2_info_ff;
         p3_speed_ff <= p2_speed_ff;
         p3_y_ff     <= y_in;
         p3_q_ff     <= q_prod[DIV9_SHIFT+QUOT_W-1:DIV9_SHIFT];
      end
      if (rdy4) begin
         p4_info_ff  <= p3_info_ff;
         p4_speed_ff <= p3_speed_ff;
         p4_inc_ff   <= inc_in;
      end
   end

   assign rsp_ch.valid           = out_v_ff;
   assign rsp_ch.frame_ok        = frame_ok_ff;
   assign rsp_ch.speed_centi_kmh = speed_ff;
   assign rsp_ch.charge_current  = current_ff;
   assign rsp_ch.charge_voltage  = voltage_ff;
   assign rsp_ch.fault_status1   = status1_ff;
   assign rsp_ch.fault_status2   = status2_ff;
   assign rsp_ch.distance_cm     = dist_ff;

   a_dist_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> dist_ff >= $past(dist_ff))
      else $error("running distance decreased");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      rdy_out && v4_ff && !p4_info_ff.chk_ok |=> $stable(speed_ff) && $stable(dist_ff))
      else $error("rejected frame changed accepted values");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !rdy_out |=> v4_ff && $stable(p4_inc_ff) && $stable(p4_speed_ff))
      else $error("stalled stage lost its contents");

endmodule

// ===== test/tb_controller_frame_receiver.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_controller_frame_receiver
// Drives motor controller frames byte by byte into the receiver and checks
// every decoded reading against an in-bench model of the checksum, speed
// scaling and saturating distance accumulation. A short directed part covers
// long, short, rejected and saturating frames. Random frames follow under
// several speed gains, with input gaps, output stalls and a long output hold.
// A final run of fast frames at the largest gain closes the run.
// ----------------------------------------------------------------------------
module tb_controller_frame_receiver;
   import cfr_pkg::*;

   localparam int CHECK_FIRST     = 1;
   localparam int CHECK_LAST      = 8;
   localparam int CHECK_POS       = 9;
   localparam int POS_SPEED_LO    = 2;
   localparam int POS_SPEED_HI    = 3;
   localparam int POS_CURRENT     = 4;
   localparam int POS_VOLTAGE     = 5;
   localparam int POS_STATUS1     = 6;
   localparam int POS_STATUS2     = 7;
   localparam int HALF_SEC_NUM    = 5;
   localparam int HALF_SEC_DEN    = 36;

   localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};
   localparam speed_type SPEED_LIMIT      = {SPEED_W{1'b1}};
   localparam dist_type  DIST_LIMIT       = {DIST_W{1'b1}};

   localparam int SETTLE_CYCLES   = 8;
   localparam int END_CYCLES      = 20;
   localparam int LONG_HOLD       = 400;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int REPORT_LIMIT    = 10;
   localparam int FAST_FRAMES     = 8;

   typedef struct packed {
      logic      frame_ok;
      speed_type speed;
      byte_type  current;
      byte_type  voltage;
      byte_type  status1;
      byte_type  status2;
      dist_type  distance;
   } reading_type;

   typedef enum logic [1:0] {READY_STEADY, READY_SPOTTY, READY_SLOW} ready_mode_type;

   logic clock = 1'b0;
   logic reset;

   cfr_req_if req_ch();
   cfr_rsp_if rsp_ch();
   cfr_csr_if csr_ch();

   controller_frame_receiver uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [GAIN_W-1:0] gain_model = GAIN_RESET;
   byte_type  frame_model [FRAME_BYTES] = '{default: '0};
   int        fill_model = 0;
   speed_type speed_model = '0;
   byte_type  current_model = '0;
   byte_type  voltage_model = '0;
   byte_type  status1_model = '0;
   byte_type  status2_model = '0;
   dist_type  distance_model = '0;

   reading_type expected_readings[$];
   byte_type    frame_tx[$];
   int          mismatch_count = 0;
   int          gap_max = 0;
   int          burst_left = 0;
   bit          long_hold_request = 1'b0;

   task automatic absorb_frame_byte(input byte_type value, input logic last);
      byte_type                    check;
      logic [PROD_W-1:0]           product;
      logic [PROD_W-GAIN_FRAC-1:0] scaled;
      logic [DIST_W:0]             total;
      reading_type                 want;
      if (fill_model < FRAME_BYTES) begin
         frame_model[fill_model] = value;
         fill_model++;
      end
      if (last) begin
         check = '0;
         for (int i = CHECK_FIRST; i <= CHECK_LAST; i++) check += frame_model[i];
         if (check == frame_model[CHECK_POS]) begin
            product = PROD_W'({frame_model[POS_SPEED_HI], frame_model[POS_SPEED_LO]})
                      * PROD_W'(gain_model);
            scaled = product[PROD_W-1:GAIN_FRAC];
            speed_model = (scaled > SPEED_LIMIT) ? SPEED_LIMIT : speed_type'(scaled);
            current_model = frame_model[POS_CURRENT];
            voltage_model = frame_model[POS_VOLTAGE];
            status1_model = frame_model[POS_STATUS1];
            status2_model = frame_model[POS_STATUS2];
            total = {1'b0, distance_model}
                    + (DIST_W+1)'((dist_type'(speed_model) * HALF_SEC_NUM) / HALF_SEC_DEN);
            distance_model = total[DIST_W] ? DIST_LIMIT : total[DIST_W-1:0];
         end
         want.frame_ok = (check == frame_model[CHECK_POS]);
         want.speed    = speed_model;
         want.current  = current_model;
         want.voltage  = voltage_model;
         want.status1  = status1_model;
         want.status2  = status2_model;
         want.distance = distance_model;
         expected_readings.push_back(want);
         foreach (frame_model[i]) frame_model[i] = '0;
         fill_model = 0;
      end
   endtask

   always @(posedge clock) begin : monitor
      reading_type got;
      reading_type want;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) gain_model = csr_ch.speed_gain;
         if (req_ch.valid && req_ch.ready) absorb_frame_byte(req_ch.rx_byte, req_ch.last_byte);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.frame_ok = rsp_ch.frame_ok;
            got.speed    = rsp_ch.speed_centi_kmh;
            got.current  = rsp_ch.charge_current;
            got.voltage  = rsp_ch.charge_voltage;
            got.status1  = rsp_ch.fault_status1;
            got.status2  = rsp_ch.fault_status2;
            got.distance = rsp_ch.distance_cm;
            if (expected_readings.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("unexpected reading: ok=%0b speed=%0d dist=%0d",
                           got.frame_ok, got.speed, got.distance);
               end
               mismatch_count++;
            end else begin
               want = expected_readings.pop_front();
               if (got.frame_ok !== want.frame_ok || got.speed !== want.speed ||
                   got.current !== want.current || got.voltage !== want.voltage ||
                   got.status1 !== want.status1 || got.status2 !== want.status2 ||
                   got.distance !== want.distance) begin
                  if (mismatch_count < REPORT_LIMIT) begin
                     $display("reading mismatch at %0t", $realtime);
                     $display("  expected ok=%0b speed=%0d cur=%0d volt=%0d st=%h/%h dist=%0d",
                              want.frame_ok, want.speed, want.current, want.voltage,
                              want.status1, want.status2, want.distance);
                     $display("  actual   ok=%0b speed=%0d cur=%0d volt=%0d st=%h/%h dist=%0d",
                              got.frame_ok, got.speed, got.current, got.voltage,
                              got.status1, got.status2, got.distance);
                  end
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin : receiver
      int             hold_left;
      int             phase_left;
      ready_mode_type mode;
      hold_left = 0;
      phase_left = 0;
      mode = READY_STEADY;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               mode = ready_mode_type'($urandom_range(0, 2));
               phase_left = $urandom_range(1, 40);
            end
            phase_left--;
            case (mode)
               READY_STEADY: rsp_ch.ready <= 1'b1;
               READY_SPOTTY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               default:      rsp_ch.ready <= (phase_left % 3 == 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb_controller_frame_receiver failed");
      $finish;
   end

   task automatic send_byte(input byte_type value, input logic last);
      if (gap_max > 0 && burst_left <= 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_ch.valid     <= 1'b1;
      req_ch.rx_byte   <= value;
      req_ch.last_byte <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic send_frame();
      int n;
      n = frame_tx.size();
      for (int i = 0; i < n; i++) send_byte(frame_tx[i], i == n - 1);
   endtask

   // make bytes 1 to 8 sum to the checksum byte, or to zero when it is missing
   task automatic seal_frame();
      int       top;
      byte_type sum;
      sum = '0;
      if (frame_tx.size() > CHECK_POS) begin
         for (int i = CHECK_FIRST; i <= CHECK_LAST; i++) sum += frame_tx[i];
         frame_tx[CHECK_POS] = sum;
      end else if (frame_tx.size() > CHECK_FIRST) begin
         top = (frame_tx.size() - 1 < CHECK_LAST) ? frame_tx.size() - 1 : CHECK_LAST;
         for (int i = CHECK_FIRST; i < top; i++) sum += frame_tx[i];
         frame_tx[top] = byte_type'(8'd0 - sum);
      end
   endtask

   task automatic build_random_frame();
      int len;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         len = $urandom_range(1, FRAME_BYTES - 1);
      end else if (pick == 1) begin
         len = $urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 4);
      end else begin
         len = FRAME_BYTES;
      end
      frame_tx.delete();
      repeat (len) frame_tx.push_back(byte_type'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) != 0) seal_frame();
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_readings.size() != 0) @(posedge clock);
   endtask

   task automatic write_speed_gain(input logic [GAIN_W-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_ch.valid      <= 1'b1;
      csr_ch.speed_gain <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic test_directed_frames();
      gap_max = 3;
      // long buffer: trailing bytes must be dropped
      frame_tx = '{8'h55, 8'h0C, 8'h34, 8'h12, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h80, 8'h00,
                   8'hFF, 8'h77};
      seal_frame();
      send_frame();
      // short buffer with a bad sum: hold previous values
      frame_tx = '{8'h00, 8'h05, 8'hFF};
      send_frame();
      // header only: all decoded bytes read as zero
      frame_tx = '{8'hFF};
      send_frame();
      // full-scale raw speed at the default gain
      frame_tx = '{8'hAA, 8'h02, 8'hFF, 8'hFF};
      send_frame();
      write_speed_gain(GAIN_MAX);
      frame_tx = '{8'h00, 8'h02, 8'hFF, 8'hFF};
      send_frame();
   endtask

   task automatic test_random_frames(input logic [GAIN_W-1:0] gain, input int budget);
      int sent;
      write_speed_gain(gain);
      gap_max = $urandom_range(0, 8);
      sent = 0;
      while (sent < budget) begin
         build_random_frame();
         send_frame();
         sent += frame_tx.size();
      end
   endtask

   task automatic test_back_pressure();
      wait_drained();
      gap_max = 0;
      long_hold_request = 1'b1;
      repeat (12) begin
         build_random_frame();
         send_frame();
      end
   endtask

   task automatic test_drain_pause();
      int half;
      gap_max = 4;
      repeat (2) begin
         build_random_frame();
         send_frame();
      end
      build_random_frame();
      half = frame_tx.size() / 2;
      for (int i = 0; i < half; i++) send_byte(frame_tx[i], 1'b0);
      wait_drained();
      for (int i = half; i < frame_tx.size(); i++) send_byte(frame_tx[i], i == frame_tx.size() - 1);
   endtask

   task automatic test_fast_frames();
      write_speed_gain(GAIN_MAX);
      gap_max = 0;
      frame_tx = '{8'h00, 8'h02, 8'hFF, 8'hFF};
      repeat (FAST_FRAMES) send_frame();
      frame_tx = '{8'h00, 8'h01};
      send_frame();
      repeat (4) begin
         build_random_frame();
         send_frame();
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.rx_byte      <= '0;
      req_ch.last_byte    <= 1'b0;
      csr_ch.valid        <= 1'b0;
      csr_ch.speed_gain   <= GAIN_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_random_frames(GAIN_RESET, 200);
      test_random_frames('0, 120);
      test_random_frames(GAIN_MAX, 160);
      test_back_pressure();
      test_random_frames(GAIN_W'($urandom_range(0, GAIN_MAX)), 200);
      test_drain_pause();
      test_random_frames(GAIN_W'($urandom_range(0, 2 ** GAIN_FRAC)), 100);
      test_fast_frames();

      wait_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("tb_controller_frame_receiver passed");
      end else begin
         $display("tb_controller_frame_receiver failed");
      end
      $finish;
   end

endmodule
